FILE: rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants of the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = ADDR_W + 1;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = QPTR_W + 1;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] REG_ENTRY_COUNT = 3'd0;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t    op;
    addr_t  idx;
    value_t value;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/stbs_in_if.sv
// ----------------------------------------------------------------------------
// stbs_in_if
// Request channel: table writes and key searches.
// ----------------------------------------------------------------------------
interface stbs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [stbs_pkg::ADDR_W-1:0]   entry_index;
  logic signed [stbs_pkg::VALUE_W-1:0] value;

  modport source (output valid, output operation, output entry_index, output value,
                  input ready);
  modport sink   (input valid, input operation, input entry_index, input value,
                  output ready);
endinterface

FILE: rtl/stbs_out_if.sv
// ----------------------------------------------------------------------------
// stbs_out_if
// Result channel: one beat per search.
// ----------------------------------------------------------------------------
interface stbs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [stbs_pkg::ADDR_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

FILE: rtl/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Table of 1024 signed 32-bit entries with a binary search lookup.
// Software sets entry_count over the APB port (byte address 0) and fills the
// table in ascending order with write beats on in_ch (operation 0). A search
// beat (operation 1) carries a key; one result beat on out_ch gives found and
// the position of the first probed match (0 when not found).
// A two-entry queue sits between the request side and the search engine, so
// in_ch keeps taking beats while a result waits on out_ch.
// Steps: a write leaves the queue and goes into the RAM in the same cycle.
// A search is dispatched from idle, then each probe is a registered RAM read
// (PROBE) followed by a compare (CMP), and DONE presents the result. A hit
// ends after the compare that matches; a miss ends in a further PROBE step
// that sees the bounds cross. A full table needs at most 11 probes.
// Reset clears the queue, the engine state and entry_count; table contents
// are unknown until written. A stalled out_ch holds the result and, once the
// queue fills, drops in_ch.ready.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top (
  input  logic                           clk,
  input  logic                           rst_n,
  stbs_in_if.sink                        in_ch,
  stbs_out_if.source                     out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [stbs_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [stbs_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [stbs_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  logic            q_valid;
  stbs_pkg::item_t q_item;
  logic            q_pop;
  stbs_pkg::cnt_t  entry_count_r, entry_count_nxt;
  logic            reg_hit;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  // word-aligned decode: low byte-lane bits ignored
  assign reg_hit    = (cfg_paddr[stbs_pkg::PADDR_W-1:2] ==
                       stbs_pkg::REG_ENTRY_COUNT[stbs_pkg::PADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    entry_count_nxt = entry_count_r;
    if (cfg_wr && reg_hit) begin
      entry_count_nxt = cfg_pwdata[stbs_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else begin
      entry_count_r <= entry_count_nxt;
    end
  end

  assign cfg_prdata = reg_hit
                      ? {{(stbs_pkg::PDATA_W-stbs_pkg::CNT_W){1'b0}}, entry_count_r}
                      : '0;

  stbs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  stbs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .entry_count (entry_count_r),
    .out_ch      (out_ch)
  );

`ifndef SYNTHESIS
  // engine never takes from an empty queue
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a full queue always has an item on offer to the engine
  a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("request side stalled with nothing queued");

  // a miss reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.position == '0))
    else $error("miss with nonzero position");

  // a result is never shown in the same cycle a new item is dispatched
  a_no_pop_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !q_pop)
    else $error("dispatch while result pending");
`endif

endmodule

FILE: rtl/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/stbs_front.sv
// ----------------------------------------------------------------------------
// stbs_front
// Accepts request beats, tags them as write or search and queues them.
// ----------------------------------------------------------------------------
module stbs_front (
  input  logic                clk,
  input  logic                rst_n,
  stbs_in_if.sink             in_ch,
  output logic                q_valid,
  output stbs_pkg::item_t     q_item,
  input  logic                q_pop
);

  stbs_pkg::item_t                  slot_r [stbs_pkg::QDEPTH];
  logic [stbs_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [stbs_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [stbs_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             push;
  logic                             pop;
  stbs_pkg::item_t                  in_item;

  function automatic logic [stbs_pkg::QCNT_W-1:0] QCNT_W_ONE(input logic b);
    QCNT_W_ONE = {{(stbs_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign in_ch.ready = (count_r != stbs_pkg::QCNT_W'(stbs_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && q_valid;

  always_comb begin
    in_item.op    = in_ch.operation ? stbs_pkg::OP_SEARCH : stbs_pkg::OP_WRITE;
    in_item.idx   = in_ch.entry_index;
    in_item.value = in_ch.value;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W_ONE(push) - QCNT_W_ONE(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

endmodule

FILE: rtl/stbs_back.sv
// ----------------------------------------------------------------------------
// stbs_back
// Carries out queued items: table writes, and the probe loop of a search.
// ----------------------------------------------------------------------------
module stbs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  stbs_pkg::item_t     q_item,
  output logic                q_pop,
  input  stbs_pkg::cnt_t      entry_count,
  stbs_out_if.source          out_ch
);

  stbs_pkg::state_t state_r, state_nxt;
  stbs_pkg::cnt_t   lo_r, lo_nxt;
  stbs_pkg::cnt_t   hx_r, hx_nxt;     // high bound plus one
  stbs_pkg::cnt_t   mid_r, mid_nxt;
  stbs_pkg::value_t key_r, key_nxt;
  logic             found_r, found_nxt;
  stbs_pkg::addr_t  pos_r, pos_nxt;

  logic             ram_we;
  logic             ram_re;
  stbs_pkg::value_t ram_rdata;
  logic [stbs_pkg::CNT_W:0] mid_sum;
  stbs_pkg::cnt_t   mid;
  stbs_pkg::cnt_t   n_clamped;
  logic             bounds_open;
  logic             key_eq;
  logic             key_lt;

  stbs_ram #(
    .WIDTH (stbs_pkg::VALUE_W),
    .DEPTH (stbs_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_item.idx),
    .wdata (q_item.value),
    .re    (ram_re),
    .raddr (mid[stbs_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // floor((lo + hi) / 2) with hi = hx - 1; hx > lo whenever it is used
  assign mid_sum     = {1'b0, lo_r} + {1'b0, hx_r} - 1'b1;
  assign mid         = mid_sum[stbs_pkg::CNT_W:1];
  assign bounds_open = (lo_r < hx_r);
  assign n_clamped   = (entry_count > stbs_pkg::CNT_W'(stbs_pkg::DEPTH))
                       ? stbs_pkg::CNT_W'(stbs_pkg::DEPTH) : entry_count;
  assign key_eq      = (key_r == ram_rdata);
  assign key_lt      = (key_r < ram_rdata);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (q_valid && q_item.op == stbs_pkg::OP_SEARCH) begin
          state_nxt = stbs_pkg::ST_PROBE;
        end
      end
      stbs_pkg::ST_PROBE: begin
        state_nxt = bounds_open ? stbs_pkg::ST_CMP : stbs_pkg::ST_DONE;
      end
      stbs_pkg::ST_CMP: begin
        state_nxt = key_eq ? stbs_pkg::ST_DONE : stbs_pkg::ST_PROBE;
      end
      stbs_pkg::ST_DONE: begin
        if (out_ch.ready) begin
          state_nxt = stbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stbs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        q_pop  = q_valid;
        ram_we = q_valid && (q_item.op == stbs_pkg::OP_WRITE);
      end
      stbs_pkg::ST_PROBE: ram_re       = bounds_open;
      stbs_pkg::ST_CMP:   ram_re       = 1'b0;
      stbs_pkg::ST_DONE:  out_ch.valid = 1'b1;
      default:            q_pop        = 1'b0;
    endcase
  end

  // search datapath
  always_comb begin
    lo_nxt    = lo_r;
    hx_nxt    = hx_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        lo_nxt    = '0;
        hx_nxt    = n_clamped;
        key_nxt   = q_item.value;
        found_nxt = 1'b0;
        pos_nxt   = '0;
      end
      stbs_pkg::ST_PROBE: mid_nxt = mid;
      stbs_pkg::ST_CMP: begin
        priority if (key_eq) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r[stbs_pkg::ADDR_W-1:0];
        end else if (key_lt) begin
          hx_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + 1'b1;
        end
      end
      stbs_pkg::ST_DONE: mid_nxt = mid_r;
      default:           mid_nxt = mid_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hx_r    <= hx_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
  end

  assign out_ch.found    = found_r;
  assign out_ch.position = pos_r;

endmodule

FILE: bench/stbs_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stbs_search_checker
// Watches the request, result and APB ports of the sorted table search block.
// Keeps its own copy of the table and of entry_count, works out the answer of
// every accepted search beat, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module stbs_search_checker
  import stbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  stbs_in_if                 in_ch,
  stbs_out_if                out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  input  logic [PDATA_W-1:0] cfg_prdata,
  input  logic               cfg_pready,
  output int unsigned        mismatches,
  output int unsigned        waiting
);

  typedef struct packed {
    logic  found;
    addr_t position;
  } answer_t;

  value_t  key_table [DEPTH];
  cnt_t    entry_count;
  answer_t answers_q [$];

  initial begin
    mismatches = 0;
    waiting    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // Closed-interval search, probe at the rounded-down midpoint, first hit wins.
  function automatic answer_t binary_lookup(input value_t key);
    int      lo;
    int      hi;
    int      mid;
    answer_t ans;
    ans = '0;
    lo  = 0;
    hi  = int'(entry_count);
    if (hi > int'(DEPTH)) hi = int'(DEPTH);
    hi = hi - 1;
    while (lo <= hi && !ans.found) begin
      mid = (lo + hi) / 2;
      if (key == key_table[mid]) begin
        ans.found    = 1'b1;
        ans.position = addr_t'(mid);
      end else if (key < key_table[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      entry_count = '0;
      answers_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == REG_ENTRY_COUNT) begin
        if (cfg_pwrite) begin
          entry_count = cfg_pwdata[CNT_W-1:0];
        end else if (cfg_prdata !== PDATA_W'(entry_count)) begin
          report_mismatch($sformatf("entry_count read 0x%0h, want 0x%0h",
                                    cfg_prdata, entry_count));
        end
      end
      // Pop before push: a result never belongs to a search taken in the same cycle.
      if (out_ch.valid && out_ch.ready) begin
        if (answers_q.size() == 0) begin
          report_mismatch($sformatf("result beat with no search waiting (found %b pos %0d)",
                                    out_ch.found, out_ch.position));
        end else begin
          want = answers_q.pop_front();
          if (out_ch.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", out_ch.found, want.found));
          if (out_ch.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d",
                                      out_ch.position, want.position));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_SEARCH)
          answers_q.push_back(binary_lookup(in_ch.value));
        else
          key_table[in_ch.entry_index] = in_ch.value;
      end
    end
    waiting <= answers_q.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sorted table binary search block. Fills the table with
// ascending runs, sets entry_count over APB between bursts, and mixes
// searches (hits, near misses, extremes, random keys) with in-order and
// out-of-order rewrites. Both handshake sides idle at random; the result
// side also holds off for a long stretch so the request queue backs up.
// ----------------------------------------------------------------------------
module tb;
  import stbs_pkg::*;

  localparam int unsigned        CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned        SETTLE_CYCLES = 32;
  localparam int unsigned        RANDOM_BEATS  = 900;
  localparam int unsigned        HOLD_CYCLES   = 300;
  localparam int unsigned        IDLE_PCT      = 29;
  localparam int unsigned        CNT_MAX       = (1 << CNT_W) - 1;
  localparam logic [PADDR_W-1:0] REG_UNMAPPED  = 3'd4;
  localparam value_t             VALUE_MIN     = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam value_t             VALUE_MAX     = ~VALUE_MIN;

  logic               clk;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  stbs_in_if  in_ch ();
  stbs_out_if out_ch ();

  int unsigned mismatches;
  int unsigned waiting;
  int unsigned cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned hold_requests = 0;
  int unsigned live_count = 0;
  bit          steady = 1'b0;
  value_t      shadow [DEPTH];
  bit          written [DEPTH];

  sorted_table_binary_search_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  stbs_search_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .waiting     (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** sorted_table_binary_search_top: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, a quiet stretch while steady, long hold on request.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_beat(input op_t op, input addr_t idx, input value_t val);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_index <= idx;
    in_ch.value       <= val;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic write_entry(input addr_t idx, input value_t val);
    send_beat(OP_WRITE, idx, val);
    shadow[idx]  = val;
    written[idx] = 1'b1;
  endtask

  task automatic search_key(input value_t key);
    send_beat(OP_SEARCH, addr_t'($urandom), key);
  endtask

  // Drop valid, wait out every pending search, then let the queue drain.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Ascending run over entries 0..n-1; zero steps give duplicate keys.
  task automatic fill_ascending(input int unsigned n);
    longint      run;
    int unsigned stride;
    stride = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 32'hFFFF_FFFF / (n + 1);
    run = -64'sd2147483648;
    if ($urandom_range(3) != 0) run += $urandom_range(0, 32'h7FFF_FFFF);
    for (int i = 0; i < int'(n); i++) begin
      if (i != 0 && $urandom_range(7) != 0) run += $urandom_range(0, stride);
      if (run > 64'sd2147483647) run = 64'sd2147483647;
      write_entry(addr_t'(i), value_t'(run));
    end
  endtask

  task automatic set_entry_count(input int unsigned n, input bit may_refill);
    int unsigned        used;
    bit                 gap;
    logic [PDATA_W-1:0] word;
    used = (n > DEPTH) ? DEPTH : n;
    gap  = 1'b0;
    for (int i = 0; i < int'(used); i++)
      if (!written[i]) gap = 1'b1;
    if (gap || (may_refill && used > 1 && used <= 400 && $urandom_range(1) == 1))
      fill_ascending(used);
    quiesce();
    // Upper bits lie outside the register and must be dropped.
    word = (may_refill && $urandom_range(3) == 0) ? $urandom : '0;
    word[CNT_W-1:0] = cnt_t'(n);
    apb_access(1'b1, REG_ENTRY_COUNT, word);
    apb_access(1'b0, REG_ENTRY_COUNT, '0);
    live_count = used;
  endtask

  function automatic value_t pick_key();
    int unsigned r;
    int unsigned j;
    r = $urandom_range(99);
    j = (live_count == 0) ? 0 : $urandom_range(0, live_count - 1);
    if (live_count != 0 && r < 50) return shadow[j];
    if (live_count != 0 && r < 62) return shadow[j] + value_t'(1);
    if (live_count != 0 && r < 74) return shadow[j] - value_t'(1);
    if (r < 78) return VALUE_MIN;
    if (r < 82) return VALUE_MAX;
    if (r < 85) return '0;
    return value_t'($urandom);
  endfunction

  task automatic random_write();
    int unsigned idx;
    longint      lo;
    longint      hi;
    if (live_count == 0 || $urandom_range(9) == 0) begin
      write_entry(addr_t'($urandom), value_t'($urandom));
    end else begin
      idx = $urandom_range(0, live_count - 1);
      if ($urandom_range(3) == 0) begin
        // break the ordering on purpose
        write_entry(addr_t'(idx), value_t'($urandom));
      end else begin
        lo = (idx == 0) ? -64'sd2147483648 : longint'(shadow[idx-1]);
        hi = (idx == live_count - 1) ? 64'sd2147483647 : longint'(shadow[idx+1]);
        if (hi < lo)
          write_entry(addr_t'(idx), shadow[idx]);
        else
          write_entry(addr_t'(idx), value_t'(lo + $urandom_range(0, hi - lo)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned burst;
    int unsigned n;
    int unsigned r;
    int unsigned phase;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.value       = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table after reset: every key misses.
    search_key('0);
    search_key(VALUE_MIN);
    search_key(VALUE_MAX);
    write_entry(addr_t'(0), VALUE_MIN);
    write_entry(addr_t'(1), -value_t'(1));
    write_entry(addr_t'(2), '0);
    write_entry(addr_t'(3), value_t'(5));
    write_entry(addr_t'(4), VALUE_MAX);
    write_entry('1, value_t'(7));
    set_entry_count(1, 1'b0);
    search_key(VALUE_MIN);
    search_key('0);
    set_entry_count(5, 1'b0);
    search_key(VALUE_MIN);
    search_key(-value_t'(1));
    search_key('0);
    search_key(value_t'(5));
    search_key(VALUE_MAX);
    search_key(value_t'(3));
    search_key(-value_t'(2));
    // Out-of-order middle entry: probes follow it wherever it leads.
    write_entry(addr_t'(2), value_t'(100));
    search_key(value_t'(100));
    search_key(value_t'(5));
    quiesce();
    apb_access(1'b1, REG_UNMAPPED, 32'h0000_0003);
    apb_access(1'b0, REG_ENTRY_COUNT, '0);

    // Full table, then a count beyond the table size.
    set_entry_count(DEPTH, 1'b0);
    search_key(VALUE_MIN);
    search_key(VALUE_MAX);
    search_key(shadow[0]);
    search_key(shadow[DEPTH/2 - 1]);
    search_key(shadow[DEPTH-1]);
    set_entry_count(CNT_MAX, 1'b0);
    search_key(shadow[DEPTH-1]);
    search_key(shadow[0]);

    base  = beats_sent;
    phase = 0;
    while (beats_sent < base + RANDOM_BEATS || phase < 5) begin
      r = $urandom_range(99);
      if (r < 6)       n = 0;
      else if (r < 12) n = 1;
      else if (r < 18) n = DEPTH;
      else if (r < 22) n = $urandom_range(DEPTH + 1, CNT_MAX);
      else if (r < 30) n = $urandom_range(65, 400);
      else             n = $urandom_range(2, 64);
      set_entry_count(n, 1'b1);
      burst = (phase == 4) ? 200 : $urandom_range(30, 90);
      if (phase == 2) hold_requests++;
      steady = (phase == 4);
      repeat (burst) begin
        if ($urandom_range(99) < 70) search_key(pick_key());
        else random_write();
      end
      steady = 1'b0;
      phase++;
    end

    quiesce();
    if (mismatches == 0)
      $display("** sorted_table_binary_search_top: PASSED **");
    else
      $display("** sorted_table_binary_search_top: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
rtl/stbs_pkg.sv
rtl/stbs_in_if.sv
rtl/stbs_out_if.sv
rtl/stbs_ram.sv
rtl/stbs_front.sv
rtl/stbs_back.sv
rtl/sorted_table_binary_search_top.sv
bench/stbs_search_checker.sv
bench/tb.sv
